// ===== hw/rtl/wcpd_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wcpd_pkg
// Shared types, codes and the fixed 80 MHz block table of the channel plan
// decoder.
// ============================================================================
package wcpd_pkg;

	// Bandwidth mode codes
	localparam logic [2:0] MODE_HT20     = 3'd0;
	localparam logic [2:0] MODE_HT40P    = 3'd1;
	localparam logic [2:0] MODE_HT40M    = 3'd2;
	localparam logic [2:0] MODE_VHT80    = 3'd3;
	localparam logic [2:0] MODE_VHT160   = 3'd4;
	localparam logic [2:0] MODE_VHT80P80 = 3'd5;

	// Error codes
	localparam logic [2:0] ERR_OK        = 3'd0;
	localparam logic [2:0] ERR_NO_BLK80  = 3'd1;
	localparam logic [2:0] ERR_NO_PAIR   = 3'd2;
	localparam logic [2:0] ERR_GAP       = 3'd3;
	localparam logic [2:0] ERR_NO_CTR2   = 3'd4;
	localparam logic [2:0] ERR_CTR2_MISS = 3'd5;
	localparam logic [2:0] ERR_BAD_MODE  = 3'd6;

	// Channel number mapping
	localparam logic [15:0] CH_MAX_NUM  = 16'd200;
	localparam logic [15:0] CH_LAST_24  = 16'd13;
	localparam logic [15:0] CH_JAPAN    = 16'd14;
	localparam logic [15:0] BASE_24     = 16'd2407;
	localparam logic [15:0] FREQ_CH14   = 16'd2484;
	localparam logic [15:0] BASE_5G     = 16'd5000;
	localparam logic [15:0] HT40_OFFSET = 16'd20;
	localparam logic [15:0] MAX_GAP     = 16'd20;

	// 80 MHz block table: lowest, highest and block center
	localparam int NBLK    = 6;
	localparam int BLK_IW  = $clog2(NBLK);
	localparam logic [BLK_IW-1:0] BLK_LAST = BLK_IW'(NBLK - 1);

	localparam logic [15:0] BLK_LO [NBLK] =
		'{16'd5180, 16'd5260, 16'd5500, 16'd5580, 16'd5660, 16'd5745};
	localparam logic [15:0] BLK_HI [NBLK] =
		'{16'd5240, 16'd5320, 16'd5560, 16'd5640, 16'd5720, 16'd5805};
	localparam logic [15:0] BLK_CTR [NBLK] =
		'{16'd5210, 16'd5290, 16'd5530, 16'd5610, 16'd5690, 16'd5775};

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] channel;
		logic [15:0] second_center;
	} req_item_t;

	typedef struct packed {
		logic [15:0] primary_freq;
		logic        band;
		logic [15:0] bond_freq;
		logic [15:0] center_one;
		logic [15:0] center_two;
		logic [15:0] low_freq;
		logic [15:0] high_freq;
		logic [2:0]  error;
	} res_item_t;

	// Decoded primary channel, passed from the channel map to the mode decoder
	typedef struct packed {
		logic [15:0]       freq;
		logic              band;
		logic              blk_hit;
		logic [BLK_IW-1:0] blk_idx;
	} chan_info_t;

endpackage

// ===== hw/rtl/wcpd_chan_map.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wcpd_chan_map
// Maps a channel number (or raw MHz above 200) to the primary 20 MHz center,
// its band and the 80 MHz block that holds it.
// ============================================================================
module wcpd_chan_map import wcpd_pkg::*; (
	input  logic [15:0] channel,
	output chan_info_t  info
);

	logic [15:0] ch_x5;
	logic [15:0] freq;
	logic        hit;
	logic [BLK_IW-1:0] idx;

	// 5 * ch as shift and add; only used for ch <= 200
	assign ch_x5 = {channel[13:0], 2'b00} + channel;

	// Channel to frequency
	always_comb begin
		priority if (channel > CH_MAX_NUM) begin
			freq = channel;
		end else if (channel == 16'd0) begin
			freq = 16'd0;
		end else if (channel <= CH_LAST_24) begin
			freq = BASE_24 + ch_x5;
		end else if (channel == CH_JAPAN) begin
			freq = FREQ_CH14;
		end else begin
			freq = BASE_5G + ch_x5;
		end
	end

	// Block lookup: six parallel range compares, lowest index wins
	always_comb begin
		hit = 1'b0;
		idx = '0;
		for (int i = NBLK - 1; i >= 0; i--) begin
			if (freq >= BLK_LO[i] && freq <= BLK_HI[i]) begin
				hit = 1'b1;
				idx = BLK_IW'(i);
			end
		end
	end

	assign info.freq    = freq;
	assign info.band    = (freq >= BASE_5G);
	assign info.blk_hit = hit;
	assign info.blk_idx = idx;

endmodule

// ===== hw/rtl/wcpd_mode_dec.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wcpd_mode_dec
// Applies the bandwidth mode to the decoded primary: HT40 bond channel, VHT
// segment centers, accepted range and error code.
// ============================================================================
module wcpd_mode_dec import wcpd_pkg::*; (
	input  logic [2:0]  mode,
	input  logic [15:0] second_center,
	input  chan_info_t  info,
	output res_item_t   res
);

	logic [BLK_IW-1:0] b;
	logic [BLK_IW-1:0] nb;
	logic [BLK_IW-1:0] b2;
	logic              b2_hit;
	logic [16:0]       pair_sum;
	logic [15:0]       f;
	logic [15:0]       bond;
	logic [15:0]       cone;
	logic [15:0]       ctwo;
	logic [15:0]       lo;
	logic [15:0]       hi;
	logic [2:0]        err;

	assign f  = info.freq;
	assign b  = info.blk_hit ? info.blk_idx : '0;
	// next block, held in range for the last block (result unused there)
	assign nb = (b == BLK_LAST) ? b : b + BLK_IW'(1);
	assign pair_sum = {1'b0, BLK_CTR[b]} + {1'b0, BLK_CTR[nb]};

	// Second segment center lookup
	always_comb begin
		b2_hit = 1'b0;
		b2     = '0;
		for (int i = NBLK - 1; i >= 0; i--) begin
			if (BLK_CTR[i] == second_center) begin
				b2_hit = 1'b1;
				b2     = BLK_IW'(i);
			end
		end
	end

	// Mode decode
	always_comb begin
		bond = '0;
		cone = '0;
		ctwo = '0;
		lo   = f;
		hi   = f;
		err  = ERR_OK;
		priority if (f == 16'd0) begin
			lo  = '0;
			hi  = '0;
			err = ERR_BAD_MODE;
		end else begin
			unique case (mode)
				MODE_HT20: begin
				end
				MODE_HT40P: begin
					bond = f + HT40_OFFSET;
					hi   = bond;
				end
				MODE_HT40M: begin
					bond = f - HT40_OFFSET;
					lo   = bond;
				end
				MODE_VHT80: begin
					if (!info.blk_hit) begin
						err = ERR_NO_BLK80;
					end else begin
						cone = BLK_CTR[b];
						lo   = BLK_LO[b];
						hi   = BLK_HI[b];
					end
				end
				MODE_VHT160: begin
					if (!info.blk_hit || b == BLK_LAST) begin
						err = ERR_NO_PAIR;
					end else if (BLK_LO[nb] - BLK_HI[b] > MAX_GAP) begin
						err = ERR_GAP;
					end else begin
						cone = pair_sum[16:1];
						lo   = BLK_LO[b];
						hi   = BLK_HI[nb];
					end
				end
				MODE_VHT80P80: begin
					if (!info.blk_hit) begin
						err = ERR_NO_BLK80;
					end else if (second_center == 16'd0) begin
						err = ERR_NO_CTR2;
					end else if (!b2_hit) begin
						err = ERR_CTR2_MISS;
					end else begin
						cone = BLK_CTR[b];
						ctwo = second_center;
						lo   = (BLK_LO[b] < BLK_LO[b2]) ? BLK_LO[b] : BLK_LO[b2];
						hi   = (BLK_HI[b] > BLK_HI[b2]) ? BLK_HI[b] : BLK_HI[b2];
					end
				end
				default: begin
					err = ERR_BAD_MODE;
				end
			endcase
			// any error on a real channel collapses to the primary alone
			if (err != ERR_OK) begin
				bond = '0;
				cone = '0;
				ctwo = '0;
				lo   = f;
				hi   = f;
			end
		end
	end

	assign res.primary_freq = f;
	assign res.band         = info.band;
	assign res.bond_freq    = bond;
	assign res.center_one   = cone;
	assign res.center_two   = ctwo;
	assign res.low_freq     = lo;
	assign res.high_freq    = hi;
	assign res.error        = err;

endmodule

// ===== hw/rtl/wifi_channel_plan_decoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wifi_channel_plan_decoder
// Wi-Fi channel plan decoder: primary frequency, band, HT40 bond, VHT centers,
// accepted channel range and error code for one request item.
// ============================================================================
// Pipeline: input register, decode logic and result register, in that order;
// the done strobe is driven by the result register.
// Throughput: one item per cycle; busy is always low.
// Reset: arst_n clears the stage valid flags; no result is strobed until
// an item is accepted after reset. The receiver cannot stall.
module wifi_channel_plan_decoder import wcpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  req_item_t request,
	output logic      done,
	output res_item_t result
);

	logic       accept;
	logic       valid_s1;
	req_item_t  req_s1;
	chan_info_t info;
	res_item_t  res_d;
	logic       valid_s2;
	res_item_t  res_s2;

	// Every cycle can take an item
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= request;
		end
	end

	// Decode
	wcpd_chan_map u_chan_map (
		.channel (req_s1.channel),
		.info    (info)
	);

	wcpd_mode_dec u_mode_dec (
		.mode          (req_s1.mode),
		.second_center (req_s1.second_center),
		.info          (info),
		.res           (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign done   = valid_s2;
	assign result = res_s2;

	// Checks
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 2))
		else $error("done without an accepted item two cycles earlier");

	a_err_collapses_range: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.error != ERR_OK && result.primary_freq != 16'd0 |->
		result.low_freq == result.primary_freq &&
		result.high_freq == result.primary_freq && result.bond_freq == 16'd0)
		else $error("error result does not collapse to the primary");

	a_low_band_no_vht: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.band |-> result.center_one == 16'd0)
		else $error("VHT center reported in the 2.4 GHz band");

	a_range_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.error == ERR_OK && result.center_one != 16'd0 |->
		result.low_freq <= result.primary_freq &&
		result.primary_freq <= result.high_freq)
		else $error("VHT range does not hold the primary");

endmodule

// ===== dv/tb_wifi_channel_plan_decoder.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_wifi_channel_plan_decoder
// Self-checking bench for the channel plan decoder. Directed items walk the
// channel map, every bandwidth mode and each error path. A long random run
// follows, sent in bursts with idle gaps. Each item is decoded here as
// well, and every strobed result is compared field by field in order.
// ============================================================================
module tb_wifi_channel_plan_decoder import wcpd_pkg::*; ();

	// Mode codes the package leaves unnamed
	localparam logic [2:0] MODE_UNKNOWN_A = 3'd6;
	localparam logic [2:0] MODE_UNKNOWN_B = 3'd7;

	localparam int NUM_BLOCKS   = 6;
	localparam int PIPE_LATENCY = 2;
	localparam int RAND_ITEMS   = 525;
	localparam int IDLE_LIMIT   = 2000;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	req_item_t request = '0;
	logic      busy;
	logic      done;
	res_item_t result;

	res_item_t pending_plans [$];
	int        items_sent    = 0;
	int        plans_checked = 0;
	int        mismatches    = 0;
	int        err_seen [8];

	wifi_channel_plan_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// 80 MHz block table: lowest and highest 20 MHz channel, and block center
	function automatic void blk_entry(input int idx, output int lo, output int hi,
			output int ctr);
		case (idx)
			0: begin lo = 5180; hi = 5240; ctr = 5210; end
			1: begin lo = 5260; hi = 5320; ctr = 5290; end
			2: begin lo = 5500; hi = 5560; ctr = 5530; end
			3: begin lo = 5580; hi = 5640; ctr = 5610; end
			4: begin lo = 5660; hi = 5720; ctr = 5690; end
			default: begin lo = 5745; hi = 5805; ctr = 5775; end
		endcase
	endfunction

	// Index of the block holding a frequency, -1 if none
	function automatic int blk_find(input int mhz);
		int lo, hi, ctr;
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			blk_entry(i, lo, hi, ctr);
			if (mhz >= lo && mhz <= hi)
				return i;
		end
		return -1;
	endfunction

	// Expected decode of one request item
	function automatic res_item_t plan_decode(input req_item_t r);
		int        f, bond, cone, ctwo, lo, hi;
		int        b, b2;
		int        lo_a, hi_a, ctr_a, lo_b, hi_b, ctr_b;
		logic [2:0] err;
		int        ch;
		res_item_t o;
		ch = int'(r.channel);
		if (ch > 200)
			f = ch;
		else if (ch >= 1 && ch <= 13)
			f = 2407 + 5 * ch;
		else if (ch == 14)
			f = 2484;
		else if (ch > 14)
			f = 5000 + 5 * ch;
		else
			f = 0;
		bond = 0;
		cone = 0;
		ctwo = 0;
		lo   = f;
		hi   = f;
		err  = ERR_OK;
		b    = blk_find(f);
		if (f == 0) begin
			lo  = 0;
			hi  = 0;
			err = ERR_BAD_MODE;
		end else begin
			case (r.mode)
				MODE_HT20: ;
				MODE_HT40P: begin
					bond = (f + 20) & 'hFFFF;
					hi   = bond;
				end
				MODE_HT40M: begin
					bond = (f - 20) & 'hFFFF;
					lo   = bond;
				end
				MODE_VHT80: begin
					if (b < 0) begin
						err = ERR_NO_BLK80;
					end else begin
						blk_entry(b, lo, hi, cone);
					end
				end
				MODE_VHT160: begin
					if (b < 0 || b + 1 >= NUM_BLOCKS) begin
						err = ERR_NO_PAIR;
					end else begin
						blk_entry(b, lo_a, hi_a, ctr_a);
						blk_entry(b + 1, lo_b, hi_b, ctr_b);
						if (lo_b - hi_a > 20) begin
							err = ERR_GAP;
						end else begin
							cone = (ctr_a + ctr_b) / 2;
							lo   = lo_a;
							hi   = hi_b;
						end
					end
				end
				MODE_VHT80P80: begin
					b2 = -1;
					for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
						blk_entry(i, lo_b, hi_b, ctr_b);
						if (ctr_b == int'(r.second_center))
							b2 = i;
					end
					if (b < 0) begin
						err = ERR_NO_BLK80;
					end else if (r.second_center == 16'd0) begin
						err = ERR_NO_CTR2;
					end else if (b2 < 0) begin
						err = ERR_CTR2_MISS;
					end else begin
						blk_entry(b, lo_a, hi_a, ctr_a);
						blk_entry(b2, lo_b, hi_b, ctr_b);
						cone = ctr_a;
						ctwo = int'(r.second_center);
						lo   = (lo_a < lo_b) ? lo_a : lo_b;
						hi   = (hi_a > hi_b) ? hi_a : hi_b;
					end
				end
				default: err = ERR_BAD_MODE;
			endcase
		end
		// any error on a real channel falls back to the bare primary
		if (err != ERR_OK && f != 0) begin
			bond = 0;
			cone = 0;
			ctwo = 0;
			lo   = f;
			hi   = f;
		end
		o.primary_freq = f[15:0];
		o.band         = (f >= 5000);
		o.bond_freq    = bond[15:0];
		o.center_one   = cone[15:0];
		o.center_two   = ctwo[15:0];
		o.low_freq     = lo[15:0];
		o.high_freq    = hi[15:0];
		o.error        = err;
		return o;
	endfunction

	// Record the expected plan of every accepted item
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			pending_plans.push_back(plan_decode(request));
	end

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %0d (0x%h), got %0d (0x%h)",
				$time, name, exp_v, exp_v, got_v, got_v);
			mismatches++;
		end
	endtask

	// Compare each strobed result with the oldest expected plan
	always @(posedge clk) begin
		res_item_t exp_plan;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (pending_plans.size() == 0) begin
					$display("%0t: result with no item pending: expected none, got %h",
						$time, result);
					mismatches++;
				end else begin
					exp_plan = pending_plans.pop_front();
					check_field("primary_freq", exp_plan.primary_freq, result.primary_freq);
					check_field("band", 16'(exp_plan.band), 16'(result.band));
					check_field("bond_freq", exp_plan.bond_freq, result.bond_freq);
					check_field("center_one", exp_plan.center_one, result.center_one);
					check_field("center_two", exp_plan.center_two, result.center_two);
					check_field("low_freq", exp_plan.low_freq, result.low_freq);
					check_field("high_freq", exp_plan.high_freq, result.high_freq);
					check_field("error", 16'(exp_plan.error), 16'(result.error));
					err_seen[exp_plan.error]++;
					plans_checked++;
				end
			end else if (done !== 1'b0) begin
				$display("%0t: done unknown: expected 0 or 1, got %b", $time, done);
				mismatches++;
			end
		end
	end

	// Watchdog: too many cycles with no accepted item and no result
	initial begin : watchdog
		int idle_count;
		idle_count = 0;
		while (idle_count < IDLE_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done === 1'b1)
				idle_count = 0;
			else
				idle_count++;
		end
		$display("%0t: watchdog expired with %0d results pending",
			$time, pending_plans.size());
		$display("CHECK FAILED");
		$finish;
	end

	// Present one item and hold it until the block takes it
	task automatic send_req(input logic [2:0] m, input logic [15:0] ch,
			input logic [15:0] c2);
		req_item_t r;
		r.mode          = m;
		r.channel       = ch;
		r.second_center = c2;
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop start and put junk on the request bus
	task automatic idle_for(input int n);
		req_item_t junk;
		if (n > 0) begin
			junk.mode          = 3'($urandom);
			junk.channel       = 16'($urandom);
			junk.second_center = 16'($urandom);
			@(negedge clk);
			start   <= 1'b0;
			request <= junk;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Stop sending until every pending result has come back
	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_plans.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	task automatic test_channel_numbers();
		// zero is not a channel; 14 is the odd one; 201 is taken as MHz
		send_req(MODE_HT20, 16'd0, 16'd0);
		send_req(MODE_HT20, 16'd1, 16'd0);
		send_req(MODE_HT20, 16'd13, 16'd0);
		send_req(MODE_HT20, 16'd14, 16'd0);
		send_req(MODE_HT20, 16'd200, 16'd0);
		send_req(MODE_HT20, 16'd201, 16'd0);
	endtask

	task automatic test_ht40();
		// HT40+ at the top of the range wraps the bond channel
		send_req(MODE_HT40P, 16'd65535, 16'd0);
		send_req(MODE_HT40P, 16'd15, 16'd5210);
		send_req(MODE_HT40M, 16'd201, 16'd0);
	endtask

	task automatic test_vht80();
		send_req(MODE_VHT80, 16'd48, 16'd0);
		send_req(MODE_VHT80, 16'd5180, 16'd0);
		send_req(MODE_VHT80, 16'd165, 16'd0);
	endtask

	task automatic test_vht160();
		// good pairs, pairs with a wide gap, and the last block
		send_req(MODE_VHT160, 16'd36, 16'd0);
		send_req(MODE_VHT160, 16'd100, 16'd0);
		send_req(MODE_VHT160, 16'd52, 16'd0);
		send_req(MODE_VHT160, 16'd140, 16'd0);
		send_req(MODE_VHT160, 16'd149, 16'd0);
	endtask

	task automatic test_vht80p80();
		send_req(MODE_VHT80P80, 16'd36, 16'd5775);
		send_req(MODE_VHT80P80, 16'd6, 16'd0);
		send_req(MODE_VHT80P80, 16'd44, 16'd0);
		send_req(MODE_VHT80P80, 16'd44, 16'd5211);
	endtask

	task automatic test_unknown_mode();
		send_req(MODE_UNKNOWN_A, 16'd36, 16'd5290);
		send_req(MODE_UNKNOWN_B, 16'd65535, 16'd65535);
		send_req(MODE_UNKNOWN_B, 16'd0, 16'd0);
	endtask

	function automatic logic [15:0] random_channel();
		case ($urandom_range(0, 9))
			0, 1:    return 16'(36 + 4 * $urandom_range(0, 32));
			2:       return 16'($urandom_range(15, 200));
			3:       return 16'($urandom_range(1, 14));
			4, 5:    return 16'($urandom_range(5170, 5815));
			6:       return 16'($urandom_range(0, 65535));
			7:       return 16'($urandom_range(65500, 65535));
			8:       return 16'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(195, 215));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] random_center();
		int lo, hi, ctr;
		blk_entry($urandom_range(0, NUM_BLOCKS - 1), lo, hi, ctr);
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'(ctr + $urandom_range(1, 5) - 3);
			2, 3:    return 16'($urandom);
			default: return 16'(ctr);
		endcase
	endfunction

	task automatic test_random_traffic();
		int burst, gap, sent;
		logic [2:0] m;
		bit drained;
		sent    = 0;
		drained = 0;
		while (sent < RAND_ITEMS) begin
			// long bursts now and then give stretches with no idling
			burst = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
			for (int i = 0; i < burst && sent < RAND_ITEMS; i++) begin
				m = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
					: 3'($urandom_range(0, 5));
				send_req(m, random_channel(), random_center());
				sent++;
			end
			if (!drained && sent >= RAND_ITEMS / 2) begin
				drain_results();
				drained = 1;
			end else begin
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				idle_for(gap);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < 8; i++)
			err_seen[i] = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		idle_for(3);

		test_channel_numbers();
		test_ht40();
		idle_for(2);
		test_vht80();
		test_vht160();
		idle_for(1);
		test_vht80p80();
		test_unknown_mode();
		test_random_traffic();

		// let the pipe empty out
		@(negedge clk);
		start <= 1'b0;
		while (pending_plans.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);

		$display("Sent %0d items, checked %0d results, %0d mismatches.",
			items_sent, plans_checked, mismatches);
		$display("Error codes seen: ok %0d, no80 %0d, nopair %0d, gap %0d,",
			err_seen[ERR_OK], err_seen[ERR_NO_BLK80], err_seen[ERR_NO_PAIR],
			err_seen[ERR_GAP]);
		$display("  noctr2 %0d, miss %0d, mode %0d",
			err_seen[ERR_NO_CTR2], err_seen[ERR_CTR2_MISS], err_seen[ERR_BAD_MODE]);
		if (mismatches == 0 && pending_plans.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
